// ----- design/jer_pkg.sv -----
// Package with shared constants, register codes and the sample fold for the entropy ring.
`default_nettype none

package jer_pkg;

	localparam int unsigned RING_DEPTH_DEF = 4096;
	localparam int unsigned WORD_W         = 32;
	localparam int unsigned SAMPLE_W       = 64;
	localparam int unsigned APB_AW         = 3;
	localparam int unsigned APB_DW         = 32;
	localparam int unsigned TICK_CNT_W     = 4;

	// A push happens on every tenth tick.
	localparam logic [TICK_CNT_W-1:0] TICK_LAST = TICK_CNT_W'(9);

	// Register index, taken from the word address bits of paddr.
	localparam logic [APB_AW-3:0] REG_CYCLE_MODE = '0;

	// Folds one timer sample into the value mixed into the accumulator.
	// Cycle-counter mode takes bits 10..3; time mode XORs six 6-bit windows
	// at shifts 0, 3, 6, 9, 12 and 15.
	function automatic logic [7:0] fold_sample(input logic [SAMPLE_W-1:0] sample,
			input logic cycle_mode);
		logic [5:0] v;
		v = '0;
		for (int s = 0; s < 16; s += 3) begin
			v = v ^ sample[s +: 6];
		end
		if (cycle_mode) begin
			return sample[10:3];
		end
		return {2'b00, v};
	endfunction

endpackage

`default_nettype wire

// ----- design/jitter_entropy_ring.sv -----
// Top level of the timer-jitter entropy collector with its ring of words.
//
// Channel   Direction  Handshake               Payload
// s_*       in         s_tvalid / s_tready     tdata: timer_value[63:0]; tuser: func
// m_*       out        m_tvalid / m_tready     tdata: random_word[31:0]; tuser: available
// APB       in/out     psel & penable & pwrite address 0: cycle_mode (bit 0)
//
// A tick is folded, mixed into the accumulator and, on every tenth tick,
// pushed into the ring memory in the cycle it is accepted.
// A read pops ring words until it finds a nonzero one or the ring is empty
// (zero words are skipped): each check cycle looks at the word fetched by the
// previous cycle and issues the next fetch, so pops follow one per cycle.
// The result then sits in the output register, and the next transaction is
// accepted while it waits there.
// Reset is asynchronous and active low; it clears the pointers, accumulator,
// tick count and mode, and the ring memory needs no clearing pass.
// A stalled result holds the block in its final state until the output
// register is free again; no input transaction is taken meanwhile.
`default_nettype none

module jitter_entropy_ring #(
	parameter int unsigned RING_DEPTH = jer_pkg::RING_DEPTH_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	// Input transactions.
	input  wire                           s_tvalid,
	output logic                          s_tready,
	input  wire  [jer_pkg::SAMPLE_W-1:0]  s_tdata,   // [63:0] timer_value
	input  wire                           s_tuser,   // [0] func: 0 tick, 1 read
	// Result transactions.
	output logic                          m_tvalid,
	input  wire                           m_tready,
	output logic [jer_pkg::WORD_W-1:0]    m_tdata,   // [31:0] random_word
	output logic                          m_tuser,   // [0] available
	// Configuration port.
	input  wire                           psel,
	input  wire                           penable,
	input  wire                           pwrite,
	input  wire  [jer_pkg::APB_AW-1:0]    paddr,
	input  wire  [jer_pkg::APB_DW-1:0]    pwdata,
	output logic [jer_pkg::APB_DW-1:0]    prdata,
	output logic                          pready
);

	localparam int unsigned PTR_W = $clog2(RING_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_EMIT
	} state_t;

	state_t                             state_q;
	logic                               cycle_mode_q;
	logic [jer_pkg::WORD_W-1:0]         acc_q;
	logic [jer_pkg::TICK_CNT_W-1:0]     tick_cnt_q;
	logic [PTR_W-1:0]                   wr_ptr_q;
	logic [PTR_W-1:0]                   rd_ptr_q;
	logic [jer_pkg::WORD_W-1:0]         res_word_q;
	logic                               res_avail_q;
	logic                               m_tvalid_q;
	logic [jer_pkg::WORD_W-1:0]         m_tdata_q;
	logic                               m_tuser_q;

	logic                               in_take;
	logic                               tick_take;
	logic                               read_take;
	logic                               push;
	logic [jer_pkg::WORD_W-1:0]         acc_mixed;
	logic [PTR_W-1:0]                   wr_next;
	logic [PTR_W-1:0]                   rd_next;
	logic                               ram_we;
	logic                               ram_re;
	logic [jer_pkg::WORD_W-1:0]         ram_rdata;
	logic                               out_free;
	logic                               cfg_write;

	// Configuration: the mode register is the only one.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		if (paddr[jer_pkg::APB_AW-1:2] == jer_pkg::REG_CYCLE_MODE) begin
			prdata = {{(jer_pkg::APB_DW-1){1'b0}}, cycle_mode_q};
		end
	end

	// Input side. Only one transaction is in work at a time; the state
	// machine itself keeps a pop from overlapping a push on the ring.
	assign s_tready  = (state_q == ST_IDLE);
	assign in_take   = s_tvalid && s_tready;
	assign tick_take = in_take && !s_tuser;
	assign read_take = in_take && s_tuser;
	assign push      = tick_take && (tick_cnt_q == jer_pkg::TICK_LAST);

	assign acc_mixed = {acc_q[jer_pkg::WORD_W-4:0], 3'b000}
		^ {{(jer_pkg::WORD_W-8){1'b0}}, jer_pkg::fold_sample(s_tdata, cycle_mode_q)};

	// Pointers wrap at the ring depth, which need not be a power of two.
	assign wr_next = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
	assign rd_next = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);

	// A pop is issued on a read when the ring is not empty, and again from
	// the check state while only zero words have turned up.
	assign ram_we = push;
	always_comb begin
		ram_re = 1'b0;
		case (state_q)
			ST_IDLE: begin
				ram_re = read_take && (rd_ptr_q != wr_ptr_q);
			end
			ST_CHECK: begin
				ram_re = (ram_rdata == '0) && (rd_ptr_q != wr_ptr_q);
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	jer_ram #(
		.WIDTH (jer_pkg::WORD_W),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_ptr_q),
		.wdata (acc_mixed),
		.re    (ram_re),
		.raddr (rd_ptr_q),
		.rdata (ram_rdata)
	);

	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cycle_mode_q <= 1'b0;
			acc_q        <= '0;
			tick_cnt_q   <= '0;
			wr_ptr_q     <= '0;
			rd_ptr_q     <= '0;
			res_avail_q  <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (cfg_write && (paddr[jer_pkg::APB_AW-1:2] == jer_pkg::REG_CYCLE_MODE)) begin
				cycle_mode_q <= pwdata[0];
			end
			// The output register is loaded from the emit state, or emptied
			// when its transaction is taken.
			if (state_q == ST_EMIT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (tick_take) begin
						if (push) begin
							tick_cnt_q <= '0;
							acc_q      <= '0;
							wr_ptr_q   <= wr_next;
							// A full ring drops its oldest word.
							if (wr_next == rd_ptr_q) begin
								rd_ptr_q <= rd_next;
							end
						end else begin
							tick_cnt_q <= tick_cnt_q + jer_pkg::TICK_CNT_W'(1);
							acc_q      <= acc_mixed;
						end
					end else if (read_take) begin
						if (rd_ptr_q == wr_ptr_q) begin
							res_avail_q <= 1'b0;
							state_q     <= ST_EMIT;
						end else begin
							rd_ptr_q <= rd_next;
							state_q  <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					if (ram_rdata != '0) begin
						res_avail_q <= 1'b1;
						state_q     <= ST_EMIT;
					end else if (rd_ptr_q == wr_ptr_q) begin
						res_avail_q <= 1'b0;
						state_q     <= ST_EMIT;
					end else begin
						rd_ptr_q <= rd_next;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result payload registers; no reset needed.
	always_ff @(posedge clk) begin
		if (state_q == ST_CHECK) begin
			res_word_q <= ram_rdata;
		end else if (read_take) begin
			res_word_q <= '0;
		end
		if (state_q == ST_EMIT && out_free) begin
			m_tdata_q <= res_avail_q ? res_word_q : '0;
			m_tuser_q <= res_avail_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// A new result only appears when leaving the emit state.
	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_EMIT))
		else $error("result appeared outside the emit state");

	// A word flagged as available is never zero.
	a_avail_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata != '0))
		else $error("available result carries a zero word");

	// The tick counter stays within 0..9.
	a_tick_range: assert property (@(posedge clk) disable iff (!arst_n)
		tick_cnt_q <= jer_pkg::TICK_LAST)
		else $error("tick counter out of range");

	// A push and a pop never reach the ring in the same cycle.
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("ring written and read in the same cycle");

	// After a push the ring is never seen as empty.
	a_push_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$past(ram_we) |-> (wr_ptr_q != rd_ptr_q))
		else $error("ring empty right after a push");

endmodule

`default_nettype wire

// ----- design/jer_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module jer_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 4096
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] waddr,
	input  wire  [WIDTH-1:0]         wdata,
	input  wire                      re,
	input  wire  [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- tb/jitter_entropy_ring_tb.sv -----
// Self-checking testbench for the timer-jitter entropy ring, with a scoreboard that predicts each read.
`default_nettype none

module jitter_entropy_ring_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned WORD_W   = jer_pkg::WORD_W;
	localparam int unsigned SAMPLE_W = jer_pkg::SAMPLE_W;
	localparam int unsigned APB_AW   = jer_pkg::APB_AW;
	localparam int unsigned APB_DW   = jer_pkg::APB_DW;

	// Kinds of input transaction, carried on s_tuser.
	localparam logic FUNC_TICK = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	localparam int unsigned DEPTH = jer_pkg::RING_DEPTH_DEF;

	// Longest run of idle or stalled cycles that the random handshakes allow.
	localparam int unsigned MAX_IDLE_RUN = 8;

	// One expected result of a read: the word and whether one was available.
	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              avail;
	} ring_word_t;

	// The scoreboard holds its own copy of the collector: accumulator, tick
	// count, ring and pointers. Every accepted input transaction is folded
	// into that copy; a read also queues the word it must return.
	class entropy_scoreboard;
		logic               mode;
		logic [WORD_W-1:0]  acc;
		logic [3:0]         ticks;
		logic [WORD_W-1:0]  words [DEPTH];
		int unsigned        wr_idx;
		int unsigned        rd_idx;
		ring_word_t         expected_words [$];
		int                 errors;

		function new();
			mode   = 1'b0;
			acc    = '0;
			ticks  = '0;
			wr_idx = 0;
			rd_idx = 0;
			errors = 0;
		endfunction

		// Value that one timer sample contributes to the accumulator.
		function logic [7:0] fold_timer(input logic [SAMPLE_W-1:0] sample);
			logic [5:0] folded;
			if (mode) begin
				return sample[10:3];
			end
			folded = sample[5:0] ^ sample[8:3] ^ sample[11:6] ^ sample[14:9]
				^ sample[17:12] ^ sample[20:15];
			return {2'b00, folded};
		endfunction

		function int unsigned ring_inc(input int unsigned idx);
			return (idx + 1 >= DEPTH) ? 0 : idx + 1;
		endfunction

		function void absorb_item(input logic func, input logic [SAMPLE_W-1:0] sample);
			ring_word_t res;
			if (func == FUNC_TICK) begin
				acc = (acc << 3) ^ WORD_W'(fold_timer(sample));
				if (ticks == jer_pkg::TICK_LAST) begin
					// A full ring drops its oldest word to make room.
					ticks          = '0;
					words[wr_idx]  = acc;
					wr_idx         = ring_inc(wr_idx);
					if (wr_idx == rd_idx) begin
						rd_idx = ring_inc(rd_idx);
					end
					acc = '0;
				end else begin
					ticks = ticks + 4'd1;
				end
				return;
			end
			// A read eats zero words until it finds a nonzero one or the ring runs dry.
			res = '0;
			while (rd_idx != wr_idx && !res.avail) begin
				res.word = words[rd_idx];
				rd_idx   = ring_inc(rd_idx);
				res.avail = (res.word != '0);
			end
			if (!res.avail) begin
				res.word = '0;
			end
			expected_words.push_back(res);
		endfunction

		function void check_word(input logic [WORD_W-1:0] word, input logic avail);
			ring_word_t exp_res;
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected result, expected none, got word %h available %0d",
					$time, word, avail);
				errors++;
				return;
			end
			exp_res = expected_words.pop_front();
			if (exp_res.word !== word || exp_res.avail !== avail) begin
				$display({"%0t: result mismatch, expected word %h available %0d, ",
					"got word %h available %0d"},
					$time, exp_res.word, exp_res.avail, word, avail);
				errors++;
			end
		endfunction

		function int pending();
			return expected_words.size();
		endfunction
	endclass

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [SAMPLE_W-1:0]  s_tdata  = '0;   // [63:0] timer_value
	logic                 s_tuser  = 1'b0; // [0] func
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [WORD_W-1:0]    m_tdata;         // [31:0] random_word
	logic                 m_tuser;         // [0] available
	logic                 psel     = 1'b0;
	logic                 penable  = 1'b0;
	logic                 pwrite   = 1'b0;
	logic [APB_AW-1:0]    paddr    = '0;
	logic [APB_DW-1:0]    pwdata   = '0;
	logic [APB_DW-1:0]    prdata;
	logic                 pready;

	entropy_scoreboard sb;

	// Percentages of idle sender cycles and stalled receiver cycles for the
	// current phase; the stimulus process sets them, the processes below read them.
	int unsigned idle_pct  = 0;
	int unsigned stall_pct = 0;
	int unsigned stall_run = 0;
	int          reg_errors = 0;

	// Ticks sent so far, so that whole windows of ten ticks can be made quiet.
	int unsigned sent_ticks = 0;
	logic        quiet_window = 1'b0;

	always #5 clk = ~clk;

	jitter_entropy_ring i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// Result side: values read at the rising edge are those from before it,
	// so a transaction is seen exactly when the block sees it. The ready
	// decision for the next cycle is made in the same step, and stalls are
	// bounded by MAX_IDLE_RUN.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_word(m_tdata, m_tuser);
		end
		if (stall_run >= MAX_IDLE_RUN || $urandom_range(99) >= stall_pct) begin
			m_tready <= 1'b1;
			stall_run = 0;
		end else begin
			m_tready <= 1'b0;
			stall_run++;
		end
	end

	// Offers one input transaction and waits until it is taken. The valid is
	// left high unless an idle gap follows, so back-to-back transactions never
	// see it lowered and raised in the same step.
	task automatic send_item(input logic func, input logic [SAMPLE_W-1:0] sample);
		int unsigned gap;
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= sample;
		do @(posedge clk); while (!s_tready);
		sb.absorb_item(func, sample);
		gap = 0;
		while (gap < MAX_IDLE_RUN && $urandom_range(99) < idle_pct) begin
			if (gap == 0) begin
				s_tvalid <= 1'b0;
			end
			@(posedge clk);
			gap++;
		end
	endtask

	// A tick with a random sample. A quarter of the windows of ten ticks are
	// quiet: their samples have the low 21 bits clear, which folds to zero in
	// both modes and so pushes a zero word that a later read has to skip.
	task automatic send_tick();
		logic [SAMPLE_W-1:0] sample;
		if (sent_ticks % 10 == 0) begin
			quiet_window = ($urandom_range(3) == 0);
		end
		sample = {$urandom, $urandom};
		if (quiet_window) begin
			sample[20:0] = '0;
		end else if ($urandom_range(15) == 0) begin
			sample = '1;
		end
		sent_ticks++;
		send_item(FUNC_TICK, sample);
	endtask

	// The timer field means nothing on a read, so it carries noise.
	task automatic send_read();
		send_item(FUNC_READ, {$urandom, $urandom});
	endtask

	task automatic random_items(input int unsigned count, input int unsigned read_pct);
		repeat (count) begin
			if ($urandom_range(99) < read_pct) begin
				send_read();
			end else begin
				send_tick();
			end
		end
	endtask

	// Holds the sender back until every expected word has arrived. A tick
	// yields no result but finishes in the cycle it is taken, so a few more
	// cycles are enough for the block to be idle.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	// One register transaction: a setup phase, then the access phase that
	// completes at the edge where pready is seen high.
	task automatic reg_access(input logic wr, input logic [APB_AW-3:0] idx,
			input logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Writes the mode, reads it back and lets the scoreboard follow.
	task automatic set_cycle_mode(input logic mode);
		logic [APB_DW-1:0] rdata;
		reg_access(1'b1, jer_pkg::REG_CYCLE_MODE,
			{$urandom_range(1) ? 31'h7FFF_FFFF : 31'h0, mode}, rdata);
		@(posedge clk);
		reg_access(1'b0, jer_pkg::REG_CYCLE_MODE, '0, rdata);
		if (rdata[0] !== mode) begin
			$display("%0t: mode read-back mismatch, expected %0d, got %0d",
				$time, mode, rdata[0]);
			reg_errors++;
		end
		sb.mode = mode;
	endtask

	initial begin
		int unsigned phase;
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening in time mode. A read on the empty ring comes first.
		send_read();
		// Ten ticks alternating an all-ones sample (which folds to zero in
		// time mode) with one that folds to one, so a nonzero word is pushed.
		for (int k = 0; k < 10; k++) begin
			send_item(FUNC_TICK, (k % 2 == 0) ? {SAMPLE_W{1'b1}} : SAMPLE_W'(1));
		end
		// Ten zero samples push a zero word behind it.
		repeat (10) send_item(FUNC_TICK, '0);
		sent_ticks = 20;
		// The first read returns the nonzero word; the second finds only the
		// zero word, consumes it and reports nothing available; the third
		// sees an empty ring again.
		repeat (3) send_read();
		drain_results();

		// Random phases over both modes and every idling profile: none, the
		// sender idle, the receiver stalling, and both a little.
		for (phase = 0; phase < 8; phase++) begin
			drain_results();
			set_cycle_mode(phase < 4);
			idle_pct  = (phase % 4 == 1) ? 52 : (phase % 4 == 3) ? 13 : 0;
			stall_pct = (phase % 4 == 2) ? 52 : (phase % 4 == 3) ? 13 : 0;
			random_items(40, 20);
			// Once, the sender waits for every outstanding word mid-phase.
			if (phase == 3) begin
				drain_results();
			end
			random_items(40, 20);
		end

		// Burst: ticks at full speed push several words back to back, then
		// reads drain them under a stalling receiver.
		drain_results();
		set_cycle_mode(1'b1);
		idle_pct  = 0;
		stall_pct = 0;
		repeat (40) send_tick();
		idle_pct  = 13;
		stall_pct = 52;
		repeat (10) send_read();
		random_items(40, 30);

		// Wait for the last word, then allow a few more cycles for anything
		// unexpected to show up before judging.
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && reg_errors == 0 && sb.pending() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// A hung handshake or a missing result ends here.
	initial begin
		#20ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire
